// ----- rtl/core/priority_ready_queue_thread_states_core_defines.svh -----
// assertion macros for the thread-state engine
`ifndef PRIORITY_READY_QUEUE_THREAD_STATES_CORE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_THREAD_STATES_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PRQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("prq assertion failed");
`define PRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("prq assertion failed");
`else
`define PRQ_ASSERT(label, prop)
`define PRQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/prq_pkg.sv -----
`timescale 1ns / 1ps
package prq_pkg;

  localparam int unsigned TID_W      = 4;
  localparam int unsigned PRIO_W     = 3;
  localparam int unsigned PIDX_W     = PRIO_W + 1;
  localparam int unsigned PRIO_MAX   = 8;
  localparam int unsigned LINK_DEPTH = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 16;

  typedef logic [TID_W-1:0]  tid_t;
  typedef logic [PRIO_W-1:0] prio_t;
  typedef logic [PIDX_W-1:0] pidx_t;

  typedef enum logic [2:0] {
    OP_RDY_INSERT = 3'd0,
    OP_RDY_REMOVE = 3'd1,
    OP_POP        = 3'd2,
    OP_FREE       = 3'd3,
    OP_ALLOC      = 3'd4,
    OP_BLOCK      = 3'd5,
    OP_UNBLOCK    = 3'd6,
    OP_QUERY      = 3'd7
  } mode_e;

  localparam logic [1:0] TS_READY    = 2'd0;
  localparam logic [1:0] TS_INACTIVE = 2'd1;
  localparam logic [1:0] TS_BLOCKED  = 2'd2;

  typedef struct packed {
    mode_e mode;
    tid_t  tid;
    prio_t priority_req;
    tid_t  running_thread;
  } prq_in_t;

  typedef struct packed {
    logic       status;
    tid_t       result_thread;
    logic [1:0] thread_state;
    logic       ready_empty;
    logic       free_empty;
  } prq_res_t;

  typedef struct packed {
    logic n_we;
    tid_t n_waddr;
    tid_t n_wdata;
    tid_t n_raddr;
    logic p_we;
    tid_t p_waddr;
    tid_t p_wdata;
    tid_t p_raddr;
  } prq_mem_req_t;

  // lowest set bit at or above from, PRIO_MAX if none
  function automatic pidx_t low_bit_from(logic [PRIO_MAX-1:0] v, pidx_t from);
    pidx_t r;
    r = PIDX_W'(PRIO_MAX);
    for (int i = PRIO_MAX - 1; i >= 0; i--) begin
      if (v[i] && (PIDX_W'(i) >= from)) r = PIDX_W'(i);
    end
    return r;
  endfunction

  function automatic prio_t high_bit(logic [PRIO_MAX-1:0] v);
    prio_t r;
    r = '0;
    for (int i = 0; i < PRIO_MAX; i++) begin
      if (v[i]) r = PRIO_W'(i);
    end
    return r;
  endfunction

  function automatic tid_t id_inc(tid_t t);
    return t + TID_W'(1);
  endfunction

  function automatic tid_t id_dec(tid_t t);
    return t - TID_W'(1);
  endfunction

endpackage

// ----- rtl/core/priority_ready_queue_thread_states_core.sv -----
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: thread, priority, running; tuser: mode
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: status, thread, state, empty flags
//
// each word steps through the issue, A and done states, and a valid ready insert also through B
// the steps are set by the registered read of the next and prev link memories,
// followed by one or two write-back steps
// after reset all links read as zero through per-entry valid bits, the ready list and the
// free stack are empty, and a word can be taken at once
// a result waiting on m_axis holds the sequencer in its final step; the next word is taken
// in the cycle the result moves into the output register
`timescale 1ns / 1ps
`include "priority_ready_queue_thread_states_core_defines.svh"
module priority_ready_queue_thread_states_core import prq_pkg::*; #(
  parameter int unsigned THREADS    = 16,
  parameter int unsigned PRIORITIES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // tid, priority_req, running_thread
  input  logic [IN_USER_W-1:0]  s_axis_tuser,  // mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // status, result_thread, thread_state,
                                               // ready_empty, free_empty
);

  localparam int unsigned OUT_PAD = OUT_DATA_W - $bits(prq_res_t);

  prq_in_t      in_word;
  prq_res_t     res, out_q;
  prq_mem_req_t mem;
  logic         res_valid, res_ready, out_vld_q;
  tid_t         n_rdata, p_rdata;

  assign in_word.mode           = mode_e'(s_axis_tuser);
  assign in_word.tid            = s_axis_tdata[3:0];
  assign in_word.priority_req   = s_axis_tdata[6:4];
  assign in_word.running_thread = s_axis_tdata[10:7];

  prq_ctrl #(
    .THREADS    (THREADS),
    .PRIORITIES (PRIORITIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_i        (in_word),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_o       (mem),
    .n_rdata_i   (n_rdata),
    .p_rdata_i   (p_rdata)
  );

  prq_ram #(
    .WIDTH (TID_W),
    .DEPTH (LINK_DEPTH)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (mem.n_we),
    .waddr_i (mem.n_waddr),
    .wdata_i (mem.n_wdata),
    .raddr_i (mem.n_raddr),
    .rdata_o (n_rdata)
  );

  prq_ram #(
    .WIDTH (TID_W),
    .DEPTH (LINK_DEPTH)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (mem.p_we),
    .waddr_i (mem.p_waddr),
    .wdata_i (mem.p_wdata),
    .raddr_i (mem.p_raddr),
    .rdata_o (p_rdata)
  );

  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_q.free_empty, out_q.ready_empty,
                          out_q.thread_state, out_q.result_thread, out_q.status};

  `PRQ_ASSERT_NEXT(a_result_loaded, res_valid && res_ready, m_axis_tvalid)

endmodule

// ----- rtl/core/prq_ram.sv -----
`timescale 1ns / 1ps
module prq_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/prq_ctrl.sv -----
`timescale 1ns / 1ps
`include "priority_ready_queue_thread_states_core_defines.svh"
module prq_ctrl import prq_pkg::*; #(
  parameter int unsigned THREADS    = 16,
  parameter int unsigned PRIORITIES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  prq_in_t      in_i,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output prq_res_t     res_o,
  output prq_mem_req_t mem_o,
  input  tid_t         n_rdata_i,
  input  tid_t         p_rdata_i
);

  localparam int unsigned PW  = $clog2(PRIORITIES);
  localparam int unsigned TW1 = TID_W + 1;
  localparam logic [TW1-1:0] THREADS_L = TW1'(THREADS);
  localparam pidx_t          PRIO_L    = PIDX_W'(PRIORITIES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_A     = 3'd2;
  localparam logic [2:0] S_B     = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] st_q, st_d;
  logic [PRIORITIES-1:0] pv_q, pv_d;
  tid_t head_q, head_d;
  tid_t fh_q, fh_d;
  logic fe_q, fe_d;
  tid_t lop_q [PRIORITIES];
  logic [LINK_DEPTH-1:0] nvld_q, pvld_q;

  mode_e op_q, op_d;
  tid_t  t_q, t_d;
  prio_t p_q, p_d;
  tid_t  run_q, run_d;
  logic  go_q, go_d;
  logic  status_q, status_d;
  tid_t  res_q, res_d;
  logic [1:0] tst_q, tst_d;
  logic  hit_q, hit_d;
  tid_t  an_q, an_d;
  tid_t  nra_q, pra_q;

  logic          lop_we;
  logic [PW-1:0] lop_wa;
  tid_t          lop_wd;
  pidx_t         lop_ra;
  tid_t          lop_rd;

  logic accept, t_ok, p_ok;
  logic [PRIO_MAX-1:0] pv8;
  logic [PRIORITIES-1:0] pbit, pv_new;
  pidx_t p_ext, idx, low0, q, low_new;
  logic found, lowlt, q_ok, rm_clr, early;
  tid_t rn, rp;

  assign pv8    = PRIO_MAX'(pv_q);
  assign p_ext  = {1'b0, p_q};
  assign pbit   = PRIORITIES'(1) << p_q[PW-1:0];
  assign idx    = low_bit_from(pv8, p_ext);
  assign found  = idx < PRIO_L;
  assign low0   = low_bit_from(pv8, '0);
  assign lowlt  = low0 < idx;
  assign q      = low_bit_from(pv8, p_ext + PIDX_W'(1));
  assign q_ok   = q < PRIO_L;

  assign rn = nvld_q[nra_q] ? n_rdata_i : '0;
  assign rp = pvld_q[pra_q] ? p_rdata_i : '0;

  always_comb begin
    if (st_q == S_ISSUE && op_q == OP_RDY_REMOVE) begin
      lop_ra = p_ext;
    end else if (st_q == S_A && op_q == OP_RDY_REMOVE) begin
      lop_ra = q;
    end else begin
      lop_ra = idx;
    end
  end

  assign lop_rd = (lop_ra < PRIO_L) ? lop_q[lop_ra[PW-1:0]] : '0;

  assign rm_clr  = hit_q && ((head_q == t_q) || (q_ok && (lop_rd == rp)));
  assign pv_new  = rm_clr ? (pv_q & ~pbit) : pv_q;
  assign low_new = low_bit_from(PRIO_MAX'(pv_new), '0);
  assign early   = hit_q && (|pv_new) && (low_new >= p_ext);

  assign t_ok = {1'b0, in_i.tid} < THREADS_L;
  assign p_ok = {1'b0, in_i.priority_req} < PRIO_L;

  assign in_ready_o  = (st_q == S_IDLE) || (st_q == S_DONE && res_ready_i);
  assign res_valid_o = (st_q == S_DONE);
  assign accept      = in_valid_i && in_ready_o;

  assign res_o.status        = status_q;
  assign res_o.result_thread = res_q;
  assign res_o.thread_state  = tst_q;
  assign res_o.ready_empty   = ~|pv_q;
  assign res_o.free_empty    = fe_q;

  always_comb begin
    st_d     = st_q;
    pv_d     = pv_q;
    head_d   = head_q;
    fh_d     = fh_q;
    fe_d     = fe_q;
    op_d     = op_q;
    t_d      = t_q;
    p_d      = p_q;
    run_d    = run_q;
    go_d     = go_q;
    status_d = status_q;
    res_d    = res_q;
    tst_d    = tst_q;
    hit_d    = hit_q;
    an_d     = an_q;
    lop_we   = 1'b0;
    lop_wa   = p_q[PW-1:0];
    lop_wd   = t_q;
    mem_o         = '0;
    mem_o.n_raddr = t_q;
    mem_o.p_raddr = t_q;

    unique case (st_q)
      S_IDLE: begin
        if (accept) st_d = S_ISSUE;
      end
      S_ISSUE: begin
        st_d = S_A;
        unique case (op_q)
          OP_RDY_INSERT: begin
            mem_o.n_raddr = lop_rd;
          end
          OP_RDY_REMOVE: begin
            hit_d = (lop_rd == t_q);
          end
          OP_ALLOC: begin
            mem_o.n_raddr = fh_q;
            mem_o.p_raddr = fh_q;
          end
          OP_FREE: begin
            if (go_q) begin
              mem_o.n_we    = 1'b1;
              mem_o.n_waddr = t_q;
              mem_o.n_wdata = fe_q ? t_q : fh_q;
              mem_o.p_we    = 1'b1;
              mem_o.p_waddr = t_q;
              mem_o.p_wdata = t_q;
              fe_d          = 1'b0;
              fh_d          = t_q;
            end
          end
          OP_BLOCK: begin
            if (go_q) begin
              mem_o.n_we    = 1'b1;
              mem_o.n_waddr = t_q;
              mem_o.n_wdata = t_q;
              mem_o.p_we    = 1'b1;
              mem_o.p_waddr = t_q;
              mem_o.p_wdata = id_inc(t_q);
            end
          end
          OP_UNBLOCK: begin
            if (go_q) begin
              mem_o.n_we    = 1'b1;
              mem_o.n_waddr = t_q;
              mem_o.n_wdata = id_dec(t_q);
              mem_o.p_we    = 1'b1;
              mem_o.p_waddr = t_q;
              mem_o.p_wdata = id_inc(t_q);
            end
          end
          default: ;
        endcase
      end
      S_A: begin
        st_d = S_DONE;
        unique case (op_q)
          OP_RDY_INSERT: begin
            if (go_q) begin
              st_d = S_B;
              an_d = rn;
              if (found) begin
                mem_o.p_we    = 1'b1;
                mem_o.p_waddr = t_q;
                mem_o.p_wdata = lop_rd;
                mem_o.n_we    = 1'b1;
                mem_o.n_waddr = lop_rd;
                mem_o.n_wdata = t_q;
              end else begin
                mem_o.n_we    = 1'b1;
                mem_o.n_waddr = t_q;
                mem_o.n_wdata = (|pv_q) ? head_q : id_inc(t_q);
                if (|pv_q) begin
                  mem_o.p_we    = 1'b1;
                  mem_o.p_waddr = head_q;
                  mem_o.p_wdata = t_q;
                end
              end
            end
          end
          OP_RDY_REMOVE: begin
            if (go_q) begin
              pv_d = pv_new;
              if (hit_q && !rm_clr) begin
                lop_we = 1'b1;
                lop_wd = rp;
              end
              if (early) begin
                mem_o.n_we    = 1'b1;
                mem_o.n_waddr = rp;
                mem_o.n_wdata = id_inc(rp);
              end else if (|pv_new) begin
                if (head_q == t_q) begin
                  mem_o.p_we    = 1'b1;
                  mem_o.p_waddr = rn;
                  mem_o.p_wdata = id_dec(rn);
                  head_d        = rn;
                end else begin
                  mem_o.p_we    = 1'b1;
                  mem_o.p_waddr = rn;
                  mem_o.p_wdata = rp;
                  mem_o.n_we    = 1'b1;
                  mem_o.n_waddr = rp;
                  mem_o.n_wdata = rn;
                end
              end
            end
          end
          OP_ALLOC: begin
            if (fe_q || (rp != fh_q)) begin
              status_d = 1'b1;
            end else begin
              res_d = fh_q;
              if (rn == fh_q) begin
                fe_d = 1'b1;
              end else begin
                fh_d = rn;
              end
              mem_o.n_we    = 1'b1;
              mem_o.n_waddr = fh_q;
              mem_o.n_wdata = id_dec(fh_q);
              mem_o.p_we    = 1'b1;
              mem_o.p_waddr = fh_q;
              mem_o.p_wdata = id_inc(fh_q);
            end
          end
          OP_QUERY: begin
            if (go_q) begin
              if (rp == t_q) begin
                tst_d = TS_INACTIVE;
              end else if ((rn == t_q) && (t_q != run_q)) begin
                tst_d = TS_BLOCKED;
              end
            end
          end
          default: ;
        endcase
      end
      S_B: begin
        st_d = S_DONE;
        if (found) begin
          mem_o.n_we    = 1'b1;
          mem_o.n_waddr = t_q;
          if (lowlt) begin
            mem_o.n_wdata = an_q;
            mem_o.p_we    = 1'b1;
            mem_o.p_waddr = an_q;
            mem_o.p_wdata = t_q;
          end else begin
            mem_o.n_wdata = id_inc(t_q);
          end
        end else begin
          mem_o.p_we    = 1'b1;
          mem_o.p_waddr = t_q;
          mem_o.p_wdata = id_dec(t_q);
          head_d        = t_q;
        end
        lop_we = 1'b1;
        pv_d   = pv_q | pbit;
      end
      S_DONE: begin
        if (res_ready_i) st_d = accept ? S_ISSUE : S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase

    if (accept) begin
      op_d     = in_i.mode;
      t_d      = in_i.tid;
      p_d      = in_i.priority_req;
      run_d    = in_i.running_thread;
      status_d = 1'b0;
      res_d    = '0;
      tst_d    = TS_READY;
      unique case (in_i.mode)
        OP_RDY_INSERT, OP_RDY_REMOVE: go_d = t_ok && p_ok;
        OP_POP: begin
          op_d     = OP_RDY_REMOVE;
          t_d      = head_q;
          p_d      = high_bit(pv8);
          go_d     = |pv_q;
          status_d = ~|pv_q;
          res_d    = (|pv_q) ? head_q : '0;
        end
        OP_ALLOC: go_d = 1'b1;
        default:  go_d = t_ok;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      pv_q   <= '0;
      head_q <= '0;
      fh_q   <= '0;
      fe_q   <= 1'b1;
      nvld_q <= '0;
      pvld_q <= '0;
      for (int i = 0; i < PRIORITIES; i++) begin
        lop_q[i] <= '0;
      end
    end else begin
      st_q   <= st_d;
      pv_q   <= pv_d;
      head_q <= head_d;
      fh_q   <= fh_d;
      fe_q   <= fe_d;
      if (mem_o.n_we) nvld_q[mem_o.n_waddr] <= 1'b1;
      if (mem_o.p_we) pvld_q[mem_o.p_waddr] <= 1'b1;
      if (lop_we) lop_q[lop_wa] <= lop_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    t_q      <= t_d;
    p_q      <= p_d;
    run_q    <= run_d;
    go_q     <= go_d;
    status_q <= status_d;
    res_q    <= res_d;
    tst_q    <= tst_d;
    hit_q    <= hit_d;
    an_q     <= an_d;
    nra_q    <= mem_o.n_raddr;
    pra_q    <= mem_o.p_raddr;
  end

  `PRQ_ASSERT_NEXT(a_insert_sets_valid, st_q == S_B, pv_q != '0)
  `PRQ_ASSERT_NEXT(a_free_clears_empty, st_q == S_ISSUE && op_q == OP_FREE && go_q, !fe_q)
  `PRQ_ASSERT(a_status_source, !(res_valid_o && res_o.status) || op_q == OP_ALLOC || op_q == OP_RDY_REMOVE)

endmodule

// ----- tb/sv/priority_ready_queue_thread_states_core_tb.sv -----
`timescale 1ns / 1ps
module priority_ready_queue_thread_states_core_tb;
  import prq_pkg::*;

  localparam int unsigned NUM_THREADS = 16;
  localparam int unsigned NUM_PRIOS   = 8;
  localparam int unsigned RAND_OPS    = 1150;
  localparam int unsigned DRAIN_AT    = 575;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum int {R_IDLE, R_LISTED, R_FREED, R_BLOCKED} role_e;

  typedef struct {
    mode_e    mode;
    tid_t     tid;
    prio_t    pri;
    tid_t     run;
    bit       typed;
    prq_res_t res;
  } op_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // shadow of the thread link table
  tid_t       nxt_link [NUM_THREADS];
  tid_t       prv_link [NUM_THREADS];
  tid_t       prio_tail [NUM_PRIOS];
  logic [7:0] prio_mask;
  tid_t       rdy_head;
  tid_t       free_top;
  logic       free_none;

  prq_res_t    reply_q [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;

  role_e role [NUM_THREADS];
  int    role_prio [NUM_THREADS];

  priority_ready_queue_thread_states_core #(
    .THREADS    (NUM_THREADS),
    .PRIORITIES (NUM_PRIOS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // tid, priority_req, running_thread
    .s_axis_tuser  (s_axis_tuser),  // mode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)   // status, result_thread, thread_state,
                                    // ready_empty, free_empty
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int first_set_from(logic [7:0] v, int from);
    for (int i = from; i < 8; i++) begin
      if (v[i]) return i;
    end
    return 8;
  endfunction

  function automatic int top_set(logic [7:0] v);
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) return i;
    end
    return 0;
  endfunction

  function automatic void sched_clear();
    for (int i = 0; i < NUM_THREADS; i++) begin
      nxt_link[i] = '0;
      prv_link[i] = '0;
    end
    for (int i = 0; i < NUM_PRIOS; i++) prio_tail[i] = '0;
    prio_mask = '0;
    rdy_head  = '0;
    free_top  = '0;
    free_none = 1'b1;
  endfunction

  function automatic void link_insert(tid_t t, int p);
    int   idx;
    tid_t after;
    tid_t after_nx;
    idx = first_set_from(prio_mask, p);
    if (idx >= 8) begin
      if (prio_mask == '0) begin
        nxt_link[t] = tid_t'(t + 1);
      end else begin
        nxt_link[t] = rdy_head;
        prv_link[rdy_head] = t;
      end
      prv_link[t] = tid_t'(t - 1);
      rdy_head = t;
    end else begin
      after = prio_tail[idx];
      after_nx = nxt_link[after];
      prv_link[t] = after;
      nxt_link[after] = t;
      if (first_set_from(prio_mask, 0) < idx) begin
        nxt_link[t] = after_nx;
        prv_link[after_nx] = t;
      end else begin
        nxt_link[t] = tid_t'(t + 1);
      end
    end
    prio_tail[p] = t;
    prio_mask[p] = 1'b1;
  endfunction

  function automatic void link_remove(tid_t t, int p);
    tid_t nx;
    tid_t pv;
    int   q;
    nx = nxt_link[t];
    pv = prv_link[t];
    if (prio_tail[p] == t) begin
      q = first_set_from(prio_mask, p + 1);
      if (rdy_head == t || (q < 8 && prio_tail[q] == pv)) begin
        prio_mask[p] = 1'b0;
      end else begin
        prio_tail[p] = pv;
      end
      if (prio_mask != '0 && first_set_from(prio_mask, 0) >= p) begin
        nxt_link[pv] = tid_t'(pv + 1);
        return;
      end
    end
    if (prio_mask != '0) begin
      if (rdy_head == t) begin
        prv_link[nx] = tid_t'(nx - 1);
        rdy_head = nx;
      end else begin
        prv_link[nx] = pv;
        nxt_link[pv] = nx;
      end
    end
  endfunction

  function automatic prq_res_t sched_apply(mode_e m, tid_t t, prio_t p, tid_t run);
    prq_res_t r;
    tid_t     h;
    bit       t_ok;
    r = '0;
    t_ok = (t < NUM_THREADS);
    case (m)
      OP_RDY_INSERT: begin
        if (t_ok && p < NUM_PRIOS) link_insert(t, int'(p));
      end
      OP_RDY_REMOVE: begin
        if (t_ok && p < NUM_PRIOS) link_remove(t, int'(p));
      end
      OP_POP: begin
        if (prio_mask == '0) begin
          r.status = 1'b1;
        end else begin
          r.result_thread = rdy_head;
          link_remove(rdy_head, top_set(prio_mask));
        end
      end
      OP_FREE: begin
        if (t_ok) begin
          if (free_none) begin
            nxt_link[t] = t;
            free_none = 1'b0;
          end else begin
            nxt_link[t] = free_top;
          end
          free_top = t;
          prv_link[t] = t;
        end
      end
      OP_ALLOC: begin
        h = free_top;
        if (free_none || prv_link[h] != h) begin
          r.status = 1'b1;
        end else begin
          r.result_thread = h;
          if (nxt_link[h] == h) free_none = 1'b1;
          else free_top = nxt_link[h];
          nxt_link[h] = tid_t'(h - 1);
          prv_link[h] = tid_t'(h + 1);
        end
      end
      OP_BLOCK: begin
        if (t_ok) begin
          nxt_link[t] = t;
          prv_link[t] = tid_t'(t + 1);
        end
      end
      OP_UNBLOCK: begin
        if (t_ok) begin
          nxt_link[t] = tid_t'(t - 1);
          prv_link[t] = tid_t'(t + 1);
        end
      end
      default: begin
        if (t_ok) begin
          if (prv_link[t] == t) r.thread_state = TS_INACTIVE;
          else if (nxt_link[t] == t && t != run) r.thread_state = TS_BLOCKED;
        end
      end
    endcase
    r.ready_empty = (prio_mask == '0);
    r.free_empty  = free_none;
    return r;
  endfunction

  function automatic int pick_role(role_e want);
    int cand [$];
    for (int i = 0; i < NUM_THREADS; i++) begin
      if (role[i] == want) cand.push_back(i);
    end
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // bursts of words with random gaps, or a full drain of pending replies
  task automatic pace_sender(input bit drain);
    int unsigned gap;
    if (drain) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (reply_q.size() != 0);
    end else if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_word(input mode_e m, input tid_t t, input prio_t p, input tid_t run,
                           input bit typed, input prq_res_t fixed, output prq_res_t got);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, run, p, t};
    s_axis_tuser  <= m;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    got = sched_apply(m, t, p, run);
    reply_q.push_back(typed ? fixed : got);
  endtask

  task automatic track_roles(input mode_e m, input tid_t t, input prio_t p,
                             input prq_res_t r);
    case (m)
      OP_RDY_INSERT: begin
        role[t] = R_LISTED;
        role_prio[t] = int'(p);
      end
      OP_RDY_REMOVE: role[t] = R_IDLE;
      OP_POP:        if (!r.status) role[r.result_thread] = R_IDLE;
      OP_FREE:       role[t] = R_FREED;
      OP_ALLOC:      if (!r.status) role[r.result_thread] = R_IDLE;
      OP_BLOCK:      role[t] = R_BLOCKED;
      OP_UNBLOCK:    role[t] = R_IDLE;
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, want, got);
    end
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    prq_res_t    e;
    int unsigned style;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          note_mismatch("unexpected word", 0, m_axis_tdata);
        end else begin
          e = reply_q.pop_front();
          if (m_axis_tdata[0] !== e.status) note_mismatch("status", e.status, m_axis_tdata[0]);
          if (m_axis_tdata[4:1] !== e.result_thread) begin
            note_mismatch("result_thread", e.result_thread, m_axis_tdata[4:1]);
          end
          if (m_axis_tdata[6:5] !== e.thread_state) begin
            note_mismatch("thread_state", e.thread_state, m_axis_tdata[6:5]);
          end
          if (m_axis_tdata[7] !== e.ready_empty) begin
            note_mismatch("ready_empty", e.ready_empty, m_axis_tdata[7]);
          end
          if (m_axis_tdata[8] !== e.free_empty) begin
            note_mismatch("free_empty", e.free_empty, m_axis_tdata[8]);
          end
          if (m_axis_tdata[15:9] !== '0) note_mismatch("padding", 0, m_axis_tdata[15:9]);
        end
      end
      style = (cycles / 256) % 4;
      case (style)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
        2:       m_axis_tready <= ((cycles % 5) < 2);
        default: m_axis_tready <= ((cycles % 16) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    op_row_t  rows [$];
    prq_res_t got;
    mode_e    m;
    tid_t     t;
    prio_t    p;
    tid_t     run;
    int       c;
    int unsigned sel;
    int unsigned k;

    sched_clear();
    for (int i = 0; i < NUM_THREADS; i++) begin
      role[i] = R_IDLE;
      role_prio[i] = 0;
    end

    rows = '{
      '{OP_QUERY,      4'd0,  3'd0, 4'd1,  1'b1, '{1'b0, 4'd0, TS_INACTIVE, 1'b1, 1'b1}},
      '{OP_POP,        4'd0,  3'd0, 4'd0,  1'b1, '{1'b1, 4'd0, TS_READY, 1'b1, 1'b1}},
      '{OP_ALLOC,      4'd0,  3'd0, 4'd0,  1'b1, '{1'b1, 4'd0, TS_READY, 1'b1, 1'b1}},
      '{OP_QUERY,      4'd5,  3'd0, 4'd0,  1'b1, '{1'b0, 4'd0, TS_READY, 1'b1, 1'b1}},
      '{OP_RDY_INSERT, 4'd3,  3'd0, 4'd0,  1'b1, '{1'b0, 4'd0, TS_READY, 1'b0, 1'b1}},
      '{OP_RDY_INSERT, 4'd9,  3'd7, 4'd0,  1'b1, '{1'b0, 4'd0, TS_READY, 1'b0, 1'b1}},
      '{OP_RDY_INSERT, 4'd12, 3'd7, 4'd0,  1'b0, '0},
      '{OP_RDY_INSERT, 4'd0,  3'd4, 4'd0,  1'b0, '0},
      '{OP_RDY_INSERT, 4'd15, 3'd7, 4'd15, 1'b0, '0},
      '{OP_POP,        4'd0,  3'd0, 4'd0,  1'b0, '0},
      '{OP_RDY_REMOVE, 4'd3,  3'd0, 4'd0,  1'b0, '0},
      '{OP_RDY_REMOVE, 4'd15, 3'd7, 4'd15, 1'b0, '0},
      '{OP_POP,        4'd0,  3'd0, 4'd0,  1'b0, '0},
      '{OP_POP,        4'd0,  3'd0, 4'd0,  1'b0, '0},
      '{OP_POP,        4'd0,  3'd0, 4'd0,  1'b0, '0},
      '{OP_FREE,       4'd15, 3'd0, 4'd0,  1'b0, '0},
      '{OP_QUERY,      4'd15, 3'd0, 4'd0,  1'b0, '0},
      '{OP_FREE,       4'd0,  3'd0, 4'd0,  1'b0, '0},
      '{OP_ALLOC,      4'd0,  3'd0, 4'd0,  1'b0, '0},
      '{OP_ALLOC,      4'd0,  3'd0, 4'd0,  1'b0, '0},
      '{OP_ALLOC,      4'd0,  3'd0, 4'd0,  1'b0, '0},
      '{OP_BLOCK,      4'd7,  3'd0, 4'd0,  1'b0, '0},
      '{OP_QUERY,      4'd7,  3'd0, 4'd0,  1'b0, '0},
      '{OP_QUERY,      4'd7,  3'd0, 4'd7,  1'b0, '0},
      '{OP_UNBLOCK,    4'd7,  3'd0, 4'd0,  1'b0, '0},
      '{OP_QUERY,      4'd7,  3'd0, 4'd0,  1'b0, '0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      pace_sender(1'b0);
      send_word(rows[i].mode, rows[i].tid, rows[i].pri, rows[i].run, rows[i].typed,
                rows[i].res, got);
      track_roles(rows[i].mode, rows[i].tid, rows[i].pri, got);
    end

    for (int n = 0; n < RAND_OPS; n++) begin
      m   = mode_e'($urandom_range(0, 7));
      t   = tid_t'($urandom_range(0, 15));
      p   = prio_t'($urandom_range(0, 7));
      run = tid_t'($urandom_range(0, 15));
      sel = $urandom_range(0, 99);
      // mostly consistent operations, the rest is raw noise
      if (sel >= 15) begin
        k = $urandom_range(0, 99);
        if (k < 26) begin
          c = pick_role(R_IDLE);
          m = (c >= 0) ? OP_RDY_INSERT : OP_POP;
          if (c >= 0) t = tid_t'(c);
        end else if (k < 38) begin
          c = pick_role(R_LISTED);
          m = (c >= 0) ? OP_RDY_REMOVE : OP_POP;
          if (c >= 0) begin
            t = tid_t'(c);
            p = prio_t'(role_prio[c]);
          end
        end else if (k < 52) begin
          m = OP_POP;
        end else if (k < 64) begin
          c = pick_role(R_IDLE);
          m = (c >= 0) ? OP_FREE : OP_ALLOC;
          if (c >= 0) t = tid_t'(c);
        end else if (k < 76) begin
          m = OP_ALLOC;
        end else if (k < 83) begin
          c = pick_role(R_IDLE);
          m = (c >= 0) ? OP_BLOCK : OP_QUERY;
          if (c >= 0) t = tid_t'(c);
        end else if (k < 88) begin
          c = pick_role(R_BLOCKED);
          m = (c >= 0) ? OP_UNBLOCK : OP_QUERY;
          if (c >= 0) t = tid_t'(c);
        end else begin
          m = OP_QUERY;
          if ($urandom_range(0, 3) == 0) run = t;
        end
      end
      pace_sender(n == DRAIN_AT);
      send_word(m, t, p, run, 1'b0, '0, got);
      track_roles(m, t, p, got);
    end

    s_axis_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
